### rtl/lea_pkg.sv
// ----------------------------------------------------------------------------
// LEA package
// Shared types and constants of the LEA block cipher core.
// ----------------------------------------------------------------------------
`default_nettype none

package lea_pkg;

  typedef logic [31:0] word_t;
  typedef logic [1:0]  kind_t;
  typedef logic [7:0]  key_index_t;
  typedef logic [5:0]  round_count_t;

  // item kinds; code 3 is accepted and dropped
  localparam kind_t KIND_KEY = 2'd0;
  localparam kind_t KIND_ENC = 2'd1;
  localparam kind_t KIND_DEC = 2'd2;

  localparam round_count_t ROUND_COUNT_RESET = 6'd24;

  localparam int WORDS_PER_ROUND = 6;
  localparam int ROT_A = 9;
  localparam int ROT_B = 5;
  localparam int ROT_C = 3;

  // key_index / 6 == (key_index * 171) >> 10 for every 8-bit key_index
  localparam logic [15:0] DIV6_MUL   = 16'd171;
  localparam int          DIV6_SHIFT = 10;

  typedef struct packed {
    logic load;    // take block words into the state
    logic step;    // run one round on the key banks' read data
    logic dec;     // inverse round
    logic emit;    // copy state to the result register
    logic key_wr;  // write key_word at key_index
  } dp_cmd_t;

  function automatic word_t rol(word_t v, int r);
    return (v << r) | (v >> (32 - r));
  endfunction

  function automatic word_t ror(word_t v, int r);
    return (v >> r) | (v << (32 - r));
  endfunction

endpackage

`default_nettype wire

### rtl/lea_if.sv
// ----------------------------------------------------------------------------
// LEA channel interfaces
// Request channel (key writes and blocks) and result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface lea_req_if;
  logic                valid;
  logic                ready;
  lea_pkg::kind_t      kind;
  lea_pkg::key_index_t key_index;
  lea_pkg::word_t      key_word;
  lea_pkg::word_t      word_a;
  lea_pkg::word_t      word_b;
  lea_pkg::word_t      word_c;
  lea_pkg::word_t      word_d;

  modport source (output valid, kind, key_index, key_word, word_a, word_b, word_c, word_d,
                  input ready);
  modport sink   (input valid, kind, key_index, key_word, word_a, word_b, word_c, word_d,
                  output ready);
endinterface

interface lea_rsp_if;
  logic           valid;
  logic           ready;
  lea_pkg::word_t out_a;
  lea_pkg::word_t out_b;
  lea_pkg::word_t out_c;
  lea_pkg::word_t out_d;

  modport source (output valid, out_a, out_b, out_c, out_d, input ready);
  modport sink   (input valid, out_a, out_b, out_c, out_d, output ready);
endinterface

`default_nettype wire

### rtl/lea_ram.sv
// ----------------------------------------------------------------------------
// LEA generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lea_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/lea_dp.sv
// ----------------------------------------------------------------------------
// LEA datapath
// Six round-key banks, the 128-bit round state and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lea_dp #(
  parameter int MAX_ROUNDS = 32
) (
  input  wire logic                          clk,
  input  wire lea_pkg::dp_cmd_t              cmd,
  input  wire logic [$clog2(MAX_ROUNDS)-1:0] rd_addr,
  input  wire lea_pkg::key_index_t           key_index,
  input  wire lea_pkg::word_t                key_word,
  input  wire lea_pkg::word_t                word_a,
  input  wire lea_pkg::word_t                word_b,
  input  wire lea_pkg::word_t                word_c,
  input  wire lea_pkg::word_t                word_d,
  output lea_pkg::word_t                     out_a,
  output lea_pkg::word_t                     out_b,
  output lea_pkg::word_t                     out_c,
  output lea_pkg::word_t                     out_d
);

  import lea_pkg::*;

  localparam int AW          = $clog2(MAX_ROUNDS);
  localparam int STORE_DEPTH = WORDS_PER_ROUND * MAX_ROUNDS;

  // bank j holds key word j of every round, addressed by round
  logic [15:0]   div_prod;
  logic [5:0]    wr_round;
  logic [7:0]    wr_rem;
  logic          wr_in_range;
  logic [WORDS_PER_ROUND-1:0] bank_we;
  word_t         k [WORDS_PER_ROUND];

  assign div_prod    = {8'd0, key_index} * DIV6_MUL;
  assign wr_round    = div_prod[DIV6_SHIFT +: 6];
  assign wr_rem      = key_index - 8'(wr_round * 8'(WORDS_PER_ROUND));
  assign wr_in_range = (9'(key_index) < 9'(STORE_DEPTH));

  for (genvar j = 0; j < WORDS_PER_ROUND; j++) begin : g_bank
    assign bank_we[j] = cmd.key_wr && wr_in_range && (wr_rem == 8'(j));

    lea_ram #(
      .WIDTH (32),
      .DEPTH (MAX_ROUNDS)
    ) u_bank (
      .clk   (clk),
      .we    (bank_we[j]),
      .waddr (wr_round[AW-1:0]),
      .wdata (key_word),
      .raddr (rd_addr),
      .rdata (k[j])
    );
  end

  word_t x0, x1, x2, x3;
  word_t e0, e1, e2;
  word_t p1, p2, p3;

  // forward round
  assign e0 = rol((x0 ^ k[0]) + (x1 ^ k[1]), ROT_A);
  assign e1 = ror((x1 ^ k[2]) + (x2 ^ k[3]), ROT_B);
  assign e2 = ror((x2 ^ k[4]) + (x3 ^ k[5]), ROT_C);

  // inverse round, x3 carries the previous first word
  assign p1 = (ror(x0, ROT_A) - (x3 ^ k[0])) ^ k[1];
  assign p2 = (rol(x1, ROT_B) - (p1 ^ k[2])) ^ k[3];
  assign p3 = (rol(x2, ROT_C) - (p2 ^ k[4])) ^ k[5];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0 <= word_a;
      x1 <= word_b;
      x2 <= word_c;
      x3 <= word_d;
    end else if (cmd.step) begin
      if (cmd.dec) begin
        x0 <= x3;
        x1 <= p1;
        x2 <= p2;
        x3 <= p3;
      end else begin
        x0 <= e0;
        x1 <= e1;
        x2 <= e2;
        x3 <= x0;
      end
    end
    if (cmd.emit) begin
      out_a <= x0;
      out_b <= x1;
      out_c <= x2;
      out_d <= x3;
    end
  end

endmodule

`default_nettype wire

### rtl/lea_ctrl.sv
// ----------------------------------------------------------------------------
// LEA controller
// Handshakes, round sequencing, round count register and result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module lea_ctrl #(
  parameter int MAX_ROUNDS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  output logic                               req_ready,
  input  wire lea_pkg::kind_t                req_kind,
  output logic                               rsp_valid,
  input  wire logic                          rsp_ready,
  input  wire logic                          cfg_we,
  input  wire lea_pkg::round_count_t         cfg_wdata,
  output lea_pkg::dp_cmd_t                   cmd,
  output logic [$clog2(MAX_ROUNDS)-1:0]      rd_addr
);

  import lea_pkg::*;

  localparam int AW = $clog2(MAX_ROUNDS);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

  state_t        state;
  round_count_t  round_count;
  logic          dec;
  logic [AW-1:0] rnd;
  logic [AW-1:0] left;

  round_count_t  n_eff;
  logic [AW-1:0] n_last;
  logic [AW-1:0] rnd_next;
  logic          accept;
  logic          is_block;
  logic          is_dec;
  logic          emit_ok;

  assign n_eff    = (round_count > 6'(MAX_ROUNDS)) ? 6'(MAX_ROUNDS) : round_count;
  assign n_last   = AW'(n_eff - 6'd1);
  assign rnd_next = dec ? (rnd - AW'(1)) : (rnd + AW'(1));
  assign accept   = req_valid && req_ready;
  assign is_dec   = (req_kind == KIND_DEC);
  assign is_block = (req_kind == KIND_ENC) || is_dec;
  assign emit_ok  = !rsp_valid || rsp_ready;

  always_comb begin
    req_ready  = (state == S_IDLE);
    cmd        = '0;
    cmd.dec    = dec;
    rd_addr    = rnd;
    unique case (state)
      S_IDLE: begin
        cmd.key_wr = accept && (req_kind == KIND_KEY);
        cmd.load   = accept && is_block;
        rd_addr    = is_dec ? n_last : '0;
      end
      S_RUN: begin
        cmd.step = 1'b1;
        rd_addr  = rnd_next;
      end
      S_DONE: begin
        cmd.emit = emit_ok;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      round_count <= ROUND_COUNT_RESET;
      rsp_valid   <= 1'b0;
      dec         <= 1'b0;
      rnd         <= '0;
      left        <= '0;
    end else begin
      if (cfg_we) begin
        round_count <= cfg_wdata;
      end
      if (state == S_DONE && emit_ok) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && is_block) begin
            dec  <= is_dec;
            rnd  <= is_dec ? n_last : '0;
            left <= n_last;
            // zero rounds: the block passes through unchanged
            state <= (n_eff == '0) ? S_DONE : S_RUN;
          end
        end
        S_RUN: begin
          if (left == '0) begin
            state <= S_DONE;
          end else begin
            rnd  <= rnd_next;
            left <= left - AW'(1);
          end
        end
        S_DONE: begin
          if (emit_ok) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/lea_block_cipher_core_top.sv
// ----------------------------------------------------------------------------
// LEA block cipher core, top level
// 128-bit LEA encrypt/decrypt with a software-loaded round-key store.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item: a round-key word write (kind 0), an encrypt block
//   (kind 1) or a decrypt block (kind 2); kind 3 is taken and dropped.
//   rsp carries one result item per encrypt or decrypt item.
//   cfg_we/cfg_wdata write the round count (reset 24, values above
//   MAX_ROUNDS run MAX_ROUNDS rounds); write it only while the core is idle.
//   Key word i lands in bank i mod 6 at round i / 6; all six banks are read
//   at once, so the core runs one round per cycle.
// Timing:
//   A key write leaves the core idle. A block runs its rounds in a loop over
//   the key banks' registered read; the state is then copied to the result
//   register, and the next item is taken once the core is back in idle.
//   If rsp is stalled the finished block waits in the core until the result
//   register is free; req stays not ready meanwhile.
//   Reset clears the round count to 24 and drops any result; the key store
//   keeps its contents and is undefined after power-up.
// ----------------------------------------------------------------------------
`default_nettype none

module lea_block_cipher_core_top #(
  parameter int MAX_ROUNDS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  lea_req_if.sink                    req,
  lea_rsp_if.source                  rsp,
  input  wire logic                  cfg_we,
  input  wire lea_pkg::round_count_t cfg_wdata
);

  import lea_pkg::*;

  dp_cmd_t                   cmd;
  logic [$clog2(MAX_ROUNDS)-1:0] rd_addr;

  lea_ctrl #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_kind  (req.kind),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .rd_addr   (rd_addr)
  );

  lea_dp #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .key_index (req.key_index),
    .key_word  (req.key_word),
    .word_a    (req.word_a),
    .word_b    (req.word_b),
    .word_c    (req.word_c),
    .word_d    (req.word_d),
    .out_a     (rsp.out_a),
    .out_b     (rsp.out_b),
    .out_c     (rsp.out_c),
    .out_d     (rsp.out_d)
  );

endmodule

`default_nettype wire

### rtl/lea_chk.sv
// ----------------------------------------------------------------------------
// LEA port checker
// Concurrent checks on the top level's ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lea_chk (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_ready,
  input wire lea_pkg::kind_t req_kind,
  input wire logic           rsp_valid,
  input wire logic           rsp_ready
);

  import lea_pkg::*;

  // the core is not ready in the cycle after it takes a block item
  a_block_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_kind == KIND_ENC || req_kind == KIND_DEC)
    |=> !req_ready)
    else $error("core ready right after taking a block");

  // key writes and dropped items leave the core idle
  a_key_idle: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && !(req_kind == KIND_ENC || req_kind == KIND_DEC)
    |=> req_ready)
    else $error("core left idle after a key write");

  // a result appears only after the core was busy with a block
  a_rsp_from_block: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> !$past(req_ready))
    else $error("result without a block in flight");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind lea_block_cipher_core_top lea_chk u_lea_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_kind  (req.kind),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready)
);

`default_nettype wire

### tb/lea_cipher_checker.sv
// ----------------------------------------------------------------------------
// LEA cipher checker
// Watches the request, result and configuration ports of the LEA core. It
// keeps its own round-key store and round count, works out the expected
// block for every encrypt or decrypt item and compares each result item,
// word by word, against the oldest expected block.
// ----------------------------------------------------------------------------
module lea_cipher_checker import lea_pkg::*; #(
  parameter int MAX_ROUNDS = 32
) (
  input  logic         clk,
  input  logic         rst,
  lea_req_if           req,
  lea_rsp_if           rsp,
  input  logic         cfg_we,
  input  round_count_t cfg_wdata,
  output int           fail_count,
  output int           pending
);

  localparam int KEY_WORDS = WORDS_PER_ROUND * MAX_ROUNDS;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } block_t;

  word_t        key_store [KEY_WORDS];
  round_count_t rounds_cfg;
  block_t       expected_blocks [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    rounds_cfg = ROUND_COUNT_RESET;
    for (int i = 0; i < KEY_WORDS; i++) key_store[i] = '0;
  end

  function automatic word_t spin_left(word_t v, int r);
    return (v << r) | (v >> (32 - r));
  endfunction

  function automatic word_t spin_right(word_t v, int r);
    return (v >> r) | (v << (32 - r));
  endfunction

  // counts above the limit run the limit
  function automatic int live_rounds();
    return (int'(rounds_cfg) > MAX_ROUNDS) ? MAX_ROUNDS : int'(rounds_cfg);
  endfunction

  function automatic block_t cipher_forward(block_t x);
    block_t y;
    int     k;
    for (int r = 0; r < live_rounds(); r++) begin
      k   = r * WORDS_PER_ROUND;
      y.a = spin_left((x.a ^ key_store[k]) + (x.b ^ key_store[k + 1]), ROT_A);
      y.b = spin_right((x.b ^ key_store[k + 2]) + (x.c ^ key_store[k + 3]), ROT_B);
      y.c = spin_right((x.c ^ key_store[k + 4]) + (x.d ^ key_store[k + 5]), ROT_C);
      y.d = x.a;
      x   = y;
    end
    return x;
  endfunction

  // inverse rounds, last round first
  function automatic block_t cipher_inverse(block_t x);
    block_t p;
    int     k;
    for (int r = live_rounds() - 1; r >= 0; r--) begin
      k   = r * WORDS_PER_ROUND;
      p.a = x.d;
      p.b = (spin_right(x.a, ROT_A) - (p.a ^ key_store[k])) ^ key_store[k + 1];
      p.c = (spin_left(x.b, ROT_B) - (p.b ^ key_store[k + 2])) ^ key_store[k + 3];
      p.d = (spin_left(x.c, ROT_C) - (p.c ^ key_store[k + 4])) ^ key_store[k + 5];
      x   = p;
    end
    return x;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic check_word(string field, word_t got, word_t want);
    if (got !== want)
      report_mismatch($sformatf("%s got %08h want %08h", field, got, want));
  endtask

  always @(posedge clk) begin
    block_t got;
    block_t want;
    block_t blk;
    if (rst) begin
      rounds_cfg = ROUND_COUNT_RESET;
      expected_blocks.delete();
    end else begin
      if (cfg_we) rounds_cfg = cfg_wdata;
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.out_a, rsp.out_b, rsp.out_c, rsp.out_d};
        if (expected_blocks.size() == 0) begin
          report_mismatch($sformatf("result item %08h %08h %08h %08h with no block waiting",
                                    got.a, got.b, got.c, got.d));
        end else begin
          want = expected_blocks.pop_front();
          check_word("out_a", got.a, want.a);
          check_word("out_b", got.b, want.b);
          check_word("out_c", got.c, want.c);
          check_word("out_d", got.d, want.d);
        end
      end
      if (req.valid && req.ready) begin
        blk = '{req.word_a, req.word_b, req.word_c, req.word_d};
        case (req.kind)
          KIND_KEY: begin
            if (int'(req.key_index) < KEY_WORDS) key_store[req.key_index] = req.key_word;
          end
          KIND_ENC: expected_blocks.push_back(cipher_forward(blk));
          KIND_DEC: expected_blocks.push_back(cipher_inverse(blk));
          default: ;
        endcase
      end
    end
    pending = expected_blocks.size();
  end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// LEA core testbench
// Sends zero-round blocks, loads the whole round-key store, then sends
// encrypt, decrypt, key-write and unused items under several round counts,
// with random request and result gaps, checked by the attached checker.
// ----------------------------------------------------------------------------
module testbench;
  import lea_pkg::*;

  localparam int    MAX_ROUNDS        = 32;
  localparam int    KEY_WORDS         = WORDS_PER_ROUND * MAX_ROUNDS;
  localparam kind_t KIND_UNUSED       = 2'd3;
  localparam int    STALL_LIMIT       = 2000;
  localparam int    SETTLE_CYCLES     = 40;
  localparam int    ITEMS_PER_SETTING = 50;
  localparam int    SWEEP_LEN         = 6;
  localparam round_count_t SWEEP [SWEEP_LEN] = '{6'd24, 6'd28, 6'd32, 6'd40, 6'd7, 6'd24};

  logic         clk = 1'b0;
  logic         rst;
  logic         cfg_we;
  round_count_t cfg_wdata;
  int           fail_count;
  int           pending;
  int           send_idle = 28;
  int           recv_idle = 56;
  int           quiet_cycles = 0;
  int           random_items = 0;

  lea_req_if req_ch ();
  lea_rsp_if rsp_ch ();

  lea_block_cipher_core_top #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  lea_cipher_checker #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  // ends the run when nothing moves for too long
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic word_t pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(kind_t k, key_index_t idx, word_t kw,
                           word_t a, word_t b, word_t c, word_t d);
    while ($urandom_range(99) < send_idle) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.kind      <= k;
    req_ch.key_index <= idx;
    req_ch.key_word  <= kw;
    req_ch.word_a    <= a;
    req_ch.word_b    <= b;
    req_ch.word_c    <= c;
    req_ch.word_d    <= d;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // drain every outstanding block, then give the core time to go idle
  task automatic settle_core();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_rounds(round_count_t n);
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_block(kind_t k, word_t a, word_t b, word_t c, word_t d);
    send_item(k, key_index_t'($urandom), word_t'($urandom), a, b, c, d);
  endtask

  initial begin
    word_t kw;
    int    pick;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    req_ch.valid     = 1'b0;
    req_ch.kind      = KIND_KEY;
    req_ch.key_index = '0;
    req_ch.key_word  = '0;
    req_ch.word_a    = '0;
    req_ch.word_b    = '0;
    req_ch.word_c    = '0;
    req_ch.word_d    = '0;
    rsp_ch.ready     = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // zero rounds: blocks pass through and no key word is used
    set_rounds(6'd0);
    send_block(KIND_ENC, '0, '0, '0, '0);
    send_block(KIND_ENC, '1, '1, '1, '1);
    send_block(KIND_DEC, '0, '0, '0, '0);
    send_block(KIND_DEC, '1, '1, '1, '1);
    send_item(KIND_UNUSED, key_index_t'($urandom), $urandom, $urandom, $urandom,
              $urandom, $urandom);
    // writes past the store are dropped
    send_item(KIND_KEY, 8'd192, '1, '0, '0, '0, '0);
    send_item(KIND_KEY, '1, '1, '0, '0, '0, '0);

    // fill every key word before any round reads one
    for (int i = 0; i < KEY_WORDS; i++) begin
      kw = (i == 0) ? word_t'('0) : (i == KEY_WORDS - 1) ? word_t'('1) : pick_word();
      send_item(KIND_KEY, key_index_t'(i), kw, $urandom, $urandom, $urandom, $urandom);
    end

    settle_core();
    set_rounds(6'd1);
    send_block(KIND_ENC, '0, '0, '0, '0);
    send_block(KIND_DEC, '1, '1, '1, '1);
    settle_core();
    set_rounds('1);
    send_block(KIND_ENC, '1, '1, '1, '1);
    send_block(KIND_DEC, '0, '0, '0, '0);
    send_block(KIND_ENC, $urandom, $urandom, $urandom, $urandom);
    settle_core();
    set_rounds(6'd32);
    send_block(KIND_ENC, $urandom, $urandom, $urandom, $urandom);
    send_block(KIND_DEC, $urandom, $urandom, $urandom, $urandom);

    for (int s = 0; s < SWEEP_LEN; s++) begin
      settle_core();
      set_rounds(SWEEP[s]);
      for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
        if (random_items < 100) begin
          send_idle = 28;
          recv_idle = 56;
        end else if (random_items < 200) begin
          send_idle = 56;
          recv_idle = 28;
        end else begin
          send_idle = 0;
          recv_idle = 0;
        end
        pick = $urandom_range(99);
        if (pick < 40)
          send_block(KIND_ENC, pick_word(), pick_word(), pick_word(), pick_word());
        else if (pick < 80)
          send_block(KIND_DEC, pick_word(), pick_word(), pick_word(), pick_word());
        else if (pick < 92)
          send_item(KIND_KEY, key_index_t'($urandom_range(255)), pick_word(),
                    $urandom, $urandom, $urandom, $urandom);
        else
          send_item(KIND_UNUSED, key_index_t'($urandom), $urandom, $urandom, $urandom,
                    $urandom, $urandom);
        random_items++;
      end
    end

    settle_core();
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
